### rtl/core/vpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vpp_pkg;

  // Fixed field widths of the vertex, result and configuration words.
  localparam int COORD_W  = 32;
  localparam int TRIG_W   = 16;
  localparam int SCREEN_W = 16;
  localparam int CFG_W    = 32;

  // Focal constant of the projection and the signed width that holds it.
  localparam int FOCAL_CONST = 350;
  localparam int FOCAL_W     = 10;

  // Reset value of the two cosine registers (1.0 in Q2.14).
  localparam logic signed [TRIG_W-1:0] TRIG_ONE = 16'sd16384;

  localparam logic [SCREEN_W-1:0] SCREEN_MAX = {1'b0, {(SCREEN_W - 1){1'b1}}};
  localparam logic [COORD_W-1:0]  DEPTH_MAX  = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam logic [COORD_W-1:0]  DEPTH_MIN  = {1'b1, {(COORD_W - 1){1'b0}}};

  typedef enum logic [2:0] {
    CFG_CAM_X,
    CFG_CAM_Y,
    CFG_CAM_Z,
    CFG_YAW_COS,
    CFG_YAW_SIN,
    CFG_PITCH_COS,
    CFG_PITCH_SIN,
    CFG_SCREEN_CENTER
  } cfg_reg_t;

  typedef struct packed {
    cfg_reg_t          index;
    logic [CFG_W-1:0]  value;
  } cfg_write_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
  } vertex_t;

  typedef struct packed {
    logic signed [SCREEN_W-1:0] screen_x;
    logic signed [SCREEN_W-1:0] screen_y;
    logic signed [COORD_W-1:0]  view_depth;
    logic                       in_front;
    logic                       depth_zero;
  } pixel_t;

endpackage

`default_nettype wire

### rtl/core/vpp_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vpp_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

### rtl/core/vpp_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined signed divider with truncation toward zero and a quotient
// saturated to Q_W signed bits. One restoring step per quotient bit.
module vpp_div #(
  parameter int NUM_W = 57,
  parameter int DEN_W = 39,
  parameter int Q_W   = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic signed [Q_W-1:0]   quo
);

  localparam int ACC_W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;
  localparam logic [Q_W-1:0] POS_MAX = {1'b0, {(Q_W - 1){1'b1}}};
  localparam logic [Q_W-1:0] NEG_MIN = {1'b1, {(Q_W - 1){1'b0}}};

  logic [NUM_W-1:0] num_abs;
  logic [DEN_W-1:0] den_abs;
  logic [ACC_W-1:0] num_mag_a;
  logic [DEN_W-1:0] den_mag_a;
  logic             neg_a;

  logic [ACC_W-1:0] rem_q [0:Q_W-1];
  logic [DEN_W-1:0] den_q [0:Q_W-1];
  logic [Q_W-1:0]   quo_q [1:Q_W];
  logic             neg_q [0:Q_W];
  logic             ovf_q [0:Q_W];

  logic [Q_W-1:0]   mag;

  assign num_abs = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
  assign den_abs = den[DEN_W-1] ? (~den + DEN_W'(1)) : den;

  // Magnitudes and result sign.
  always_ff @(posedge clk) begin
    if (en) begin
      num_mag_a <= ACC_W'(num_abs);
      den_mag_a <= den_abs;
      neg_a     <= num[NUM_W-1] ^ den[DEN_W-1];
    end
  end

  // A quotient of 2^Q_W or more saturates whatever its sign.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= num_mag_a;
      den_q[0] <= den_mag_a;
      neg_q[0] <= neg_a;
      ovf_q[0] <= num_mag_a >= (ACC_W'(den_mag_a) << Q_W);
    end
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic [ACC_W-1:0] shifted;
    logic [ACC_W:0]   diff;
    logic [Q_W-1:0]   q_in;

    assign shifted = ACC_W'(den_q[i]) << (Q_W - 1 - i);
    assign diff    = {1'b0, rem_q[i]} - {1'b0, shifted};

    if (i == 0) begin : g_first
      assign q_in = '0;
    end else begin : g_rest
      assign q_in = quo_q[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[i+1] <= {q_in[Q_W-2:0], ~diff[ACC_W]};
        neg_q[i+1] <= neg_q[i];
        ovf_q[i+1] <= ovf_q[i];
      end
    end

    if (i < Q_W - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i+1] <= diff[ACC_W] ? rem_q[i] : diff[ACC_W-1:0];
          den_q[i+1] <= den_q[i];
        end
      end
    end
  end

  assign mag = quo_q[Q_W];

  // Apply the sign and clamp to the signed range.
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_q[Q_W]) begin
        quo <= (ovf_q[Q_W] || (mag > NEG_MIN)) ? NEG_MIN : (~mag + Q_W'(1));
      end else begin
        quo <= (ovf_q[Q_W] || mag[Q_W-1]) ? POS_MAX : mag;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/vertex_perspective_projection_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role    Word                      Transfer
// --------  ------  ------------------------  ---------------------------
// cfg       sink    index, value              valid & ready (ready is 1)
// vertex    sink    vertex_x/y/z, Q16.16      valid & ready
// pixel     source  screen_x/y, view_depth,   valid & ready
//                   in_front, depth_zero
//
// One vertex word enters per cycle unless a stall on pixel holds the pipeline;
// the divider spends one stage per quotient bit.
// rst is synchronous and clears the valid bits and the skid buffer; it also
// resets the configuration registers; no clearing pass is needed.
// A stall on pixel freezes the whole pipeline; a single skid register at the
// input still takes one more vertex word, so vertex.ready is registered.
module vertex_perspective_projection_core #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst,
  vpp_stream_if.sink   cfg,
  vpp_stream_if.sink   vertex,
  vpp_stream_if.source pixel
);

  // Datapath widths. Each rotation adds two products of a coordinate and a
  // 16-bit trig value and drops TRIG_FRAC_BITS fraction bits by floor.
  localparam int SUM_W  = vpp_pkg::COORD_W + 1;
  localparam int P1_W   = SUM_W + vpp_pkg::TRIG_W;
  localparam int R1_W   = P1_W + 1 - TRIG_FRAC_BITS;
  localparam int P2_W   = R1_W + vpp_pkg::TRIG_W;
  localparam int R2_W   = P2_W + 1 - TRIG_FRAC_BITS;
  localparam int CEN_W  = vpp_pkg::SCREEN_W + 1;
  localparam int PJ_W   = R2_W + CEN_W;
  localparam int NUM_W  = PJ_W + 1;

  // Divider: magnitude stage, range check, one stage per quotient bit and a
  // final sign/saturate stage.
  localparam int DIV_LAT = vpp_pkg::SCREEN_W + 3;
  localparam int STAGES  = 7 + DIV_LAT + 1;
  localparam int SIDE_N  = DIV_LAT + 2;

  localparam logic signed [vpp_pkg::FOCAL_W-1:0] FOCAL =
    vpp_pkg::FOCAL_W'(vpp_pkg::FOCAL_CONST);

  typedef struct packed {
    logic signed [vpp_pkg::COORD_W-1:0] view_depth;
    logic                               in_front;
    logic                               depth_zero;
    logic [vpp_pkg::SCREEN_W-1:0]       center_x;
    logic [vpp_pkg::SCREEN_W-1:0]       center_y;
  } side_t;

  // Configuration registers.
  logic signed [vpp_pkg::COORD_W-1:0] cam_x;
  logic signed [vpp_pkg::COORD_W-1:0] cam_y;
  logic signed [vpp_pkg::COORD_W-1:0] cam_z;
  logic signed [vpp_pkg::TRIG_W-1:0]  yaw_cos;
  logic signed [vpp_pkg::TRIG_W-1:0]  yaw_sin;
  logic signed [vpp_pkg::TRIG_W-1:0]  pitch_cos;
  logic signed [vpp_pkg::TRIG_W-1:0]  pitch_sin;
  logic [vpp_pkg::CFG_W-1:0]          screen_center;

  // Flow control.
  logic              en;
  logic              in_take;
  logic              skid_valid;
  vpp_pkg::vertex_t  skid_q;
  vpp_pkg::vertex_t  src;
  logic [STAGES:1]   vld;

  // Pipeline payload, suffix is the stage number.
  logic signed [SUM_W-1:0]   x1, y1, z1;
  logic signed [P1_W-1:0]    pxc2, pzs2, pxs2, pzc2;
  logic signed [SUM_W-1:0]   y2;
  logic signed [P1_W:0]      rot_x, rot_z;
  logic signed [R1_W-1:0]    xr3, zr3;
  logic signed [SUM_W-1:0]   y3;
  logic signed [P2_W-1:0]    pyc4, pzs4, pys4, pzc4;
  logic signed [R1_W-1:0]    xr4;
  logic signed [P2_W:0]      rot_y, rot_d;
  logic signed [R2_W-1:0]    yr5, zd5;
  logic signed [R1_W-1:0]    xr5;
  logic signed [CEN_W-1:0]   cen_x, cen_y;
  logic signed [PJ_W-1:0]    pax6, pay6, pcx6, pcy6;
  logic signed [R2_W-1:0]    zd6;
  logic signed [NUM_W-1:0]   numx7, numy7;
  logic signed [R2_W-1:0]    zd7;
  logic signed [vpp_pkg::SCREEN_W-1:0] quo_x, quo_y;

  logic [R2_W-vpp_pkg::COORD_W:0] depth_hi;
  logic                           depth_fits;
  side_t                          side_next;
  side_t                          side_q [0:SIDE_N-1];
  side_t                          side_out;
  vpp_pkg::pixel_t                pixel_q;

  // ---------------------------------------------------------------------
  // Configuration port. Writes must be issued only while the block is idle;
  // the block does not enforce it. Every stage reads the registers directly.
  // ---------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x         <= '0;
      cam_y         <= '0;
      cam_z         <= '0;
      yaw_cos       <= vpp_pkg::TRIG_ONE;
      yaw_sin       <= '0;
      pitch_cos     <= vpp_pkg::TRIG_ONE;
      pitch_sin     <= '0;
      screen_center <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        vpp_pkg::CFG_CAM_X:         cam_x <= cfg.data.value;
        vpp_pkg::CFG_CAM_Y:         cam_y <= cfg.data.value;
        vpp_pkg::CFG_CAM_Z:         cam_z <= cfg.data.value;
        vpp_pkg::CFG_YAW_COS:       yaw_cos <= cfg.data.value[vpp_pkg::TRIG_W-1:0];
        vpp_pkg::CFG_YAW_SIN:       yaw_sin <= cfg.data.value[vpp_pkg::TRIG_W-1:0];
        vpp_pkg::CFG_PITCH_COS:     pitch_cos <= cfg.data.value[vpp_pkg::TRIG_W-1:0];
        vpp_pkg::CFG_PITCH_SIN:     pitch_sin <= cfg.data.value[vpp_pkg::TRIG_W-1:0];
        vpp_pkg::CFG_SCREEN_CENTER: screen_center <= cfg.data.value;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Flow control. The whole pipeline moves together whenever the output
  // register is empty or being drained. The skid register catches the one
  // word that may be accepted during a stall, and is drained first.
  // ---------------------------------------------------------------------
  assign en           = !vld[STAGES] || pixel.ready;
  assign vertex.ready = !skid_valid;
  assign in_take      = vertex.valid && vertex.ready;
  assign src          = skid_valid ? skid_q : vertex.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      skid_valid <= 1'b0;
    end else begin
      if (en) begin
        vld        <= {vld[STAGES-1:1], skid_valid | in_take};
        skid_valid <= 1'b0;
      end else if (in_take) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && !en) begin
      skid_q <= vertex.data;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 1-5: camera offset, then yaw and pitch rotations. Each rotation
  // takes one stage of products and one stage of sums; keeping the upper
  // bits of the sum is the floor shift by TRIG_FRAC_BITS.
  // ---------------------------------------------------------------------
  assign rot_x = {pxc2[P1_W-1], pxc2} - {pzs2[P1_W-1], pzs2};
  assign rot_z = {pxs2[P1_W-1], pxs2} + {pzc2[P1_W-1], pzc2};
  assign rot_y = {pyc4[P2_W-1], pyc4} - {pzs4[P2_W-1], pzs4};
  assign rot_d = {pys4[P2_W-1], pys4} + {pzc4[P2_W-1], pzc4};

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= {src.vertex_x[vpp_pkg::COORD_W-1], src.vertex_x} +
            {cam_x[vpp_pkg::COORD_W-1], cam_x};
      y1 <= {src.vertex_y[vpp_pkg::COORD_W-1], src.vertex_y} +
            {cam_y[vpp_pkg::COORD_W-1], cam_y};
      z1 <= {src.vertex_z[vpp_pkg::COORD_W-1], src.vertex_z} +
            {cam_z[vpp_pkg::COORD_W-1], cam_z};

      pxc2 <= x1 * yaw_cos;
      pzs2 <= z1 * yaw_sin;
      pxs2 <= x1 * yaw_sin;
      pzc2 <= z1 * yaw_cos;
      y2   <= y1;

      xr3 <= rot_x[P1_W:TRIG_FRAC_BITS];
      zr3 <= rot_z[P1_W:TRIG_FRAC_BITS];
      y3  <= y2;

      pyc4 <= y3 * pitch_cos;
      pzs4 <= zr3 * pitch_sin;
      pys4 <= y3 * pitch_sin;
      pzc4 <= zr3 * pitch_cos;
      xr4  <= xr3;

      yr5 <= rot_y[P2_W:TRIG_FRAC_BITS];
      zd5 <= rot_d[P2_W:TRIG_FRAC_BITS];
      xr5 <= xr4;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 6-7: the division numerator coord * 350 + center * depth, so
  // that one truncating division gives trunc(coord * 350 / depth + center).
  // ---------------------------------------------------------------------
  assign cen_x = {1'b0, screen_center[vpp_pkg::SCREEN_W-1:0]};
  assign cen_y = {1'b0, screen_center[vpp_pkg::CFG_W-1:vpp_pkg::SCREEN_W]};

  always_ff @(posedge clk) begin
    if (en) begin
      pax6 <= xr5 * FOCAL;
      pay6 <= yr5 * FOCAL;
      pcx6 <= cen_x * zd5;
      pcy6 <= cen_y * zd5;
      zd6  <= zd5;

      numx7 <= {pax6[PJ_W-1], pax6} + {pcx6[PJ_W-1], pcx6};
      numy7 <= {pay6[PJ_W-1], pay6} + {pcy6[PJ_W-1], pcy6};
      zd7   <= zd6;
    end
  end

  // The flags and the clamped depth come from the exact depth. A zero depth
  // shows the center, clamped to the positive screen range.
  assign depth_hi   = zd5[R2_W-1:vpp_pkg::COORD_W-1];
  assign depth_fits = (&depth_hi) || !(|depth_hi);

  always_comb begin
    side_next.view_depth = depth_fits ? zd5[vpp_pkg::COORD_W-1:0] :
                           (zd5[R2_W-1] ? vpp_pkg::DEPTH_MIN : vpp_pkg::DEPTH_MAX);
    side_next.in_front   = zd5[R2_W-1];
    side_next.depth_zero = (zd5 == '0);
    side_next.center_x   = cen_x[vpp_pkg::SCREEN_W-1] ? vpp_pkg::SCREEN_MAX :
                           cen_x[vpp_pkg::SCREEN_W-1:0];
    side_next.center_y   = cen_y[vpp_pkg::SCREEN_W-1] ? vpp_pkg::SCREEN_MAX :
                           cen_y[vpp_pkg::SCREEN_W-1:0];
  end

  // Side information rides alongside the divider.
  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_next;
      for (int i = 1; i < SIDE_N; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Dividers, one per screen axis, sharing the depth.
  // ---------------------------------------------------------------------
  vpp_div #(
    .NUM_W (NUM_W),
    .DEN_W (R2_W),
    .Q_W   (vpp_pkg::SCREEN_W)
  ) u_div_x (
    .clk (clk),
    .en  (en),
    .num (numx7),
    .den (zd7),
    .quo (quo_x)
  );

  vpp_div #(
    .NUM_W (NUM_W),
    .DEN_W (R2_W),
    .Q_W   (vpp_pkg::SCREEN_W)
  ) u_div_y (
    .clk (clk),
    .en  (en),
    .num (numy7),
    .den (zd7),
    .quo (quo_y)
  );

  // ---------------------------------------------------------------------
  // Output register. On zero depth the divider result is ignored.
  // ---------------------------------------------------------------------
  assign side_out = side_q[SIDE_N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_q.screen_x   <= side_out.depth_zero ? side_out.center_x : quo_x;
      pixel_q.screen_y   <= side_out.depth_zero ? side_out.center_y : quo_y;
      pixel_q.view_depth <= side_out.view_depth;
      pixel_q.in_front   <= side_out.in_front;
      pixel_q.depth_zero <= side_out.depth_zero;
    end
  end

  assign pixel.valid = vld[STAGES];
  assign pixel.data  = pixel_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // A word taken during a stall must land in the skid register.
  a_skid_capture: assert property (@(posedge clk) disable iff (rst)
    (vertex.valid && vertex.ready && !en) |=> skid_valid)
    else $error("vertex word accepted during stall was not held in skid");

  // A stall freezes every valid bit of the pipeline.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  // Depth clamping must keep the sign that sets in_front.
  a_front_sign: assert property (@(posedge clk) disable iff (rst)
    pixel.valid |-> (pixel.data.in_front == pixel.data.view_depth[vpp_pkg::COORD_W-1]))
    else $error("in_front disagrees with the sign of view_depth");

  // Zero depth gives a zero depth word and a clamped, non-negative center.
  a_zero_depth: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.data.depth_zero) |->
      ((pixel.data.view_depth == '0) && !pixel.data.in_front &&
       !pixel.data.screen_x[vpp_pkg::SCREEN_W-1] &&
       !pixel.data.screen_y[vpp_pkg::SCREEN_W-1]))
    else $error("zero-depth word is inconsistent");

endmodule

`default_nettype wire

### verif/vertex_perspective_projection_core_tb.sv
`timescale 1ns / 1ps

localparam int     TRIG_FRAC = 14;
localparam longint SCREEN_HI = longint'(vpp_pkg::SCREEN_MAX);
localparam longint SCREEN_LO = -SCREEN_HI - 1;
localparam longint DEPTH_HI  = longint'(vpp_pkg::DEPTH_MAX);
localparam longint DEPTH_LO  = -DEPTH_HI - 1;

// Keeps a private copy of the camera registers, computes the pixel word of
// every accepted vertex word and checks the pixel words in arrival order.
class projection_scoreboard;
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic signed [15:0] yaw_cos, yaw_sin, pitch_cos, pitch_sin;
  logic [31:0]        center;
  vpp_pkg::pixel_t    expected_pixels[$];
  int                 mismatches;

  function new();
    cam_x      = '0;
    cam_y      = '0;
    cam_z      = '0;
    yaw_cos    = vpp_pkg::TRIG_ONE;
    yaw_sin    = '0;
    pitch_cos  = vpp_pkg::TRIG_ONE;
    pitch_sin  = '0;
    center     = '0;
    mismatches = 0;
  endfunction

  function void write_reg(vpp_pkg::cfg_reg_t idx, logic [31:0] value);
    case (idx)
      vpp_pkg::CFG_CAM_X:         cam_x     = value;
      vpp_pkg::CFG_CAM_Y:         cam_y     = value;
      vpp_pkg::CFG_CAM_Z:         cam_z     = value;
      vpp_pkg::CFG_YAW_COS:       yaw_cos   = value[15:0];
      vpp_pkg::CFG_YAW_SIN:       yaw_sin   = value[15:0];
      vpp_pkg::CFG_PITCH_COS:     pitch_cos = value[15:0];
      vpp_pkg::CFG_PITCH_SIN:     pitch_sin = value[15:0];
      vpp_pkg::CFG_SCREEN_CENTER: center    = value;
      default: ;
    endcase
  endfunction

  function longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Exact quotient of (coord * focal + center * depth) / depth, truncated and clamped.
  function logic signed [15:0] screen_coord(longint coord, longint depth, longint cen);
    longint num;
    num = coord * vpp_pkg::FOCAL_CONST + cen * depth;
    return 16'(clamp(num / depth, SCREEN_LO, SCREEN_HI));
  endfunction

  function vpp_pkg::pixel_t project_vertex(vpp_pkg::vertex_t v);
    longint x, y, z, xr, zr, yr, zd, cen_x, cen_y;
    vpp_pkg::pixel_t p;
    x = longint'($signed(v.vertex_x)) + longint'(cam_x);
    y = longint'($signed(v.vertex_y)) + longint'(cam_y);
    z = longint'($signed(v.vertex_z)) + longint'(cam_z);
    // Arithmetic shifts of the signed products round toward minus infinity.
    xr = (x * longint'(yaw_cos) - z * longint'(yaw_sin)) >>> TRIG_FRAC;
    zr = (x * longint'(yaw_sin) + z * longint'(yaw_cos)) >>> TRIG_FRAC;
    yr = (y * longint'(pitch_cos) - zr * longint'(pitch_sin)) >>> TRIG_FRAC;
    zd = (y * longint'(pitch_sin) + zr * longint'(pitch_cos)) >>> TRIG_FRAC;
    cen_x = longint'(center[15:0]);
    cen_y = longint'(center[31:16]);
    if (zd == 0) begin
      p.screen_x = 16'(clamp(cen_x, SCREEN_LO, SCREEN_HI));
      p.screen_y = 16'(clamp(cen_y, SCREEN_LO, SCREEN_HI));
    end else begin
      p.screen_x = screen_coord(xr, zd, cen_x);
      p.screen_y = screen_coord(yr, zd, cen_y);
    end
    p.view_depth = 32'(clamp(zd, DEPTH_LO, DEPTH_HI));
    p.in_front   = (zd < 0);
    p.depth_zero = (zd == 0);
    return p;
  endfunction

  function void note_vertex(vpp_pkg::vertex_t v);
    expected_pixels = {expected_pixels, project_vertex(v)};
  endfunction

  function void compare_field(string name, logic signed [31:0] want,
                              logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s differs, expected %0d, got %0d", $realtime, name, want, got);
    end
  endfunction

  function void check_pixel(vpp_pkg::pixel_t got);
    vpp_pkg::pixel_t want;
    if (expected_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: pixel word arrived with no vertex word pending", $realtime);
      return;
    end
    want = expected_pixels.pop_front();
    compare_field("screen_x", want.screen_x, got.screen_x);
    compare_field("screen_y", want.screen_y, got.screen_y);
    compare_field("view_depth", want.view_depth, got.view_depth);
    compare_field("in_front", want.in_front, got.in_front);
    compare_field("depth_zero", want.depth_zero, got.depth_zero);
  endfunction

  function int pending();
    return expected_pixels.size();
  endfunction
endclass

module vertex_perspective_projection_core_tb;

  // One full set of camera registers, written as a group between phases.
  typedef struct packed {
    logic [31:0] cam_x;
    logic [31:0] cam_y;
    logic [31:0] cam_z;
    logic [15:0] yaw_cos;
    logic [15:0] yaw_sin;
    logic [15:0] pitch_cos;
    logic [15:0] pitch_sin;
    logic [31:0] center;
  } camera_t;

  localparam int                 ONE    = 65536;  // 1.0 in Q16.16
  localparam logic signed [31:0] C_MAX  = 32'sh7fffffff;
  localparam logic signed [31:0] C_MIN  = 32'sh80000000;
  localparam int                 BATCH  = 110;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;

  projection_scoreboard sb;

  vpp_stream_if #(.payload_t(vpp_pkg::cfg_write_t)) cfg_ch ();
  vpp_stream_if #(.payload_t(vpp_pkg::vertex_t))    vertex_ch ();
  vpp_stream_if #(.payload_t(vpp_pkg::pixel_t))     pixel_ch ();

  vertex_perspective_projection_core #(
    .TRIG_FRAC_BITS(TRIG_FRAC)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .vertex(vertex_ch),
    .pixel (pixel_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver drops ready at random; the idle share changes per phase.
  always @(posedge clk) begin
    pixel_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // All three channels are observed at the same edge the block sees them,
  // so register writes, vertex words and pixel words reach the scoreboard
  // in the order the block took them.
  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready)
      sb.write_reg(cfg_ch.data.index, cfg_ch.data.value);
    if (!rst && vertex_ch.valid && vertex_ch.ready)
      sb.note_vertex(vertex_ch.data);
    if (!rst && pixel_ch.valid && pixel_ch.ready)
      sb.check_pixel(pixel_ch.data);
  end

  // Presents one vertex word after a random gap and holds it until it is
  // taken. Valid stays high on return so back-to-back words need no gap.
  task automatic send_vertex(vpp_pkg::vertex_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      vertex_ch.valid <= 1'b0;
      @(posedge clk);
    end
    vertex_ch.valid <= 1'b1;
    vertex_ch.data  <= v;
    do @(posedge clk); while (!vertex_ch.ready);
  endtask

  // Stops the vertex stream and waits until every pixel word is back. This
  // is what makes the block idle before the camera registers change.
  task automatic drain_pixels();
    vertex_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_cfg(vpp_pkg::cfg_reg_t idx, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, value: value};
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // The trig registers take only the low half of the word; the upper half
  // carries noise to show that it is ignored.
  task automatic apply_camera(camera_t c);
    write_cfg(vpp_pkg::CFG_CAM_X, c.cam_x);
    write_cfg(vpp_pkg::CFG_CAM_Y, c.cam_y);
    write_cfg(vpp_pkg::CFG_CAM_Z, c.cam_z);
    write_cfg(vpp_pkg::CFG_YAW_COS, {16'($urandom), c.yaw_cos});
    write_cfg(vpp_pkg::CFG_YAW_SIN, {16'($urandom), c.yaw_sin});
    write_cfg(vpp_pkg::CFG_PITCH_COS, {16'($urandom), c.pitch_cos});
    write_cfg(vpp_pkg::CFG_PITCH_SIN, {16'($urandom), c.pitch_sin});
    write_cfg(vpp_pkg::CFG_SCREEN_CENTER, c.center);
    cfg_ch.valid <= 1'b0;
  endtask

  // Coordinates mix full-range noise with scene-sized values, values near
  // zero (so depth can land on zero), random magnitudes and the extremes.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(9))
      0, 1, 2:    return $urandom;
      3, 4, 5, 6: return int'($urandom_range(600 * ONE)) - 300 * ONE;
      7:          return int'($urandom_range(32)) - 16;
      8:          return int'($urandom) >>> $urandom_range(31);
      default: begin
        case ($urandom_range(3))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return '0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // Mostly proper cosine and sine values, sometimes any 16-bit pattern.
  function automatic logic [15:0] rand_trig();
    if ($urandom_range(9) < 7)
      return 16'(int'($urandom_range(32768)) - 16384);
    return 16'($urandom);
  endfunction

  function automatic camera_t random_camera();
    camera_t c;
    c.cam_x = ($urandom_range(9) < 4) ? '0 : rand_coord();
    c.cam_y = ($urandom_range(9) < 4) ? '0 : rand_coord();
    c.cam_z = ($urandom_range(9) < 4) ? '0 : rand_coord();
    // An unrotated camera now and then keeps zero depth within reach.
    if ($urandom_range(4) == 0) begin
      c.yaw_cos   = vpp_pkg::TRIG_ONE;
      c.yaw_sin   = '0;
      c.pitch_cos = vpp_pkg::TRIG_ONE;
      c.pitch_sin = '0;
    end else begin
      c.yaw_cos   = rand_trig();
      c.yaw_sin   = rand_trig();
      c.pitch_cos = rand_trig();
      c.pitch_sin = rand_trig();
    end
    c.center = $urandom_range(1) ? $urandom
                                 : {16'($urandom_range(480)), 16'($urandom_range(640))};
    return c;
  endfunction

  initial begin
    camera_t c;
    sb = new();
    rst             = 1'b1;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    vertex_ch.valid = 1'b0;
    vertex_ch.data  = '0;
    pixel_ch.ready  = 1'b0;
    send_idle_pct   = 25;
    recv_idle_pct   = 88;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset camera: no offset, no rotation, center at the origin. Covers
    // zero depth, depth on both sides, truncation of negative quotients,
    // saturation of the screen values and depth at the 32-bit limits.
    send_vertex('{32'sd0, 32'sd0, 32'sd0});
    send_vertex('{ONE, 2 * ONE, -10 * ONE});
    send_vertex('{-5 * ONE, 3 * ONE, 7 * ONE});
    send_vertex('{C_MAX, C_MAX, -32'sd1});
    send_vertex('{C_MAX, C_MIN, 32'sd1});
    send_vertex('{C_MIN, C_MAX, 32'sd1});
    send_vertex('{C_MAX, C_MAX, C_MAX});
    send_vertex('{C_MIN, C_MIN, C_MIN});
    send_vertex('{32'sd1, -32'sd1, -32'sd3});
    send_vertex('{32'sd0, 32'sd0, -32'sd1});
    send_vertex('{32'sh0000ffff, 32'shffff0001, 32'sh00010000});

    // Extreme camera: offsets at both limits, trig of -2.0 and just under
    // 2.0, and a center beyond the signed range on both axes. The sums
    // overflow 32 bits, so view_depth must saturate.
    drain_pixels();
    c = '{cam_x: C_MAX, cam_y: C_MIN, cam_z: C_MAX,
          yaw_cos: 16'h8000, yaw_sin: 16'h7fff,
          pitch_cos: 16'hc000, pitch_sin: 16'h4000,
          center: 32'hffff_ffff};
    apply_camera(c);
    send_vertex('{32'sd0, 32'sd0, 32'sd0});
    send_vertex('{C_MAX, C_MAX, C_MAX});
    send_vertex('{C_MIN, C_MIN, C_MIN});
    send_vertex('{C_MAX, C_MIN, C_MIN});

    // Camera with unit trig values and a depth offset. Here depth reduces to
    // x - (z + 5.0) - y, so the first two words land exactly on zero depth
    // and must return the saturated center.
    drain_pixels();
    c = '{cam_x: 32'd0, cam_y: 32'd0, cam_z: 5 * ONE,
          yaw_cos: 16'hc000, yaw_sin: 16'h4000,
          pitch_cos: 16'h4000, pitch_sin: 16'hc000,
          center: 32'hffff_8000};
    apply_camera(c);
    send_vertex('{3 * ONE, ONE, -3 * ONE});
    send_vertex('{32'sd0, 32'sd0, -5 * ONE});
    send_vertex('{ONE, 32'sd0, -5 * ONE});
    send_vertex('{32'sd0, 100 * ONE, -5 * ONE});

    // Random part in three idle profiles: slow receiver, slow sender, and
    // full rate. Each batch runs under a fresh random camera, and every
    // change of camera waits for the pipeline to empty first.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int b = 0; b < 5; b++) begin
        drain_pixels();
        apply_camera(random_camera());
        for (int i = 0; i < BATCH; i++)
          send_vertex('{rand_coord(), rand_coord(), rand_coord()});
      end
    end

    // Let the pipeline empty, then keep watching to catch any extra pixel word.
    drain_pixels();
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
